@@ rtl/rad_pkg.sv @@
// ----------------------------------------------------------------------------
// rad_pkg
// Shared widths, descriptor layout and constants of the receive deframer.
// ----------------------------------------------------------------------------
package rad_pkg;

  localparam int unsigned BufferBytesDefault = 16384;

  localparam int unsigned DataW  = 8;
  localparam int unsigned BlenW  = 15;
  localparam int unsigned PosW   = 15;
  localparam int unsigned LenW   = 14;
  localparam int unsigned CountW = 8;

  // slave tdata: data_byte, buffer_length, zero fill
  localparam int unsigned STdataW = 24;
  // master tdata: packet_byte, packet_length, zero fill
  localparam int unsigned MTdataW = 24;

  localparam logic [LenW-1:0] MaxPacketReset = 14'd2346;

  localparam logic [7:0] DescBytes = 8'd24;
  localparam logic [7:0] UnitAlign = 8'd128;

  // byte offsets inside the descriptor
  localparam logic [PosW-1:0] RelCount  = 15'd10;
  localparam logic [PosW-1:0] RelReport = 15'd13;

  // descriptor word 0 bit positions
  localparam int unsigned CrcErrBit    = 14;
  localparam int unsigned IcvErrBit    = 15;
  localparam int unsigned SwDecryptBit = 27;

  // security types
  localparam logic [2:0] SecNone = 3'd0;
  localparam logic [2:0] SecTkip = 3'd2;
  localparam logic [2:0] SecAes  = 3'd4;

endpackage

@@ rtl/rx_aggregate_deframer.sv @@
// ----------------------------------------------------------------------------
// rx_aggregate_deframer
// Splits one aggregated receive transfer, one byte per transaction, into the
// packets it carries and forwards the bytes of the accepted packets.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: data_byte, buffer_length; tlast: last_byte
//  m_*      out  m_tvalid/m_tready    tdata: packet_byte, packet_length;
//                                     tuser: packet_start; tlast: packet_end
//  cfg_*    in   cfg_valid/cfg_ready  cfg_data: max_packet_size
//
//  one byte per cycle while s_tready is high; each byte is parsed in the cycle it is
//  accepted and its result, if any, appears in the output register on the next cycle
//  s_tready is low only while the output register holds a result that
//  m_tready does not take
//  rst (synchronous) clears the parse state and the output valid m_tvalid and sets
//  max_packet_size to 2346; cfg_ready is always high
//
module rx_aggregate_deframer #(
  parameter int unsigned BUFFER_BYTES = rad_pkg::BufferBytesDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rad_pkg::STdataW-1:0] s_tdata,   // [7:0] data_byte, [22:8] buffer_length
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rad_pkg::MTdataW-1:0] m_tdata,   // [7:0] packet_byte, [21:8] packet_length
  output logic                       m_tuser,   // [0] packet_start
  output logic                       m_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rad_pkg::LenW-1:0]   cfg_data
);
  import rad_pkg::*;

  localparam logic [16:0] BufLimit = 17'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    PH_DESC,
    PH_GAP,
    PH_PAYLOAD,
    PH_PAD,
    PH_STOP
  } phase_t;

  // parse state
  phase_t             phase, phase_next;
  logic [PosW-1:0]    byte_position, byte_position_next;
  logic [PosW-1:0]    unit_start, unit_start_next;
  logic [31:0]        descriptor_word_zero, descriptor_word_zero_next;
  logic [1:0]         report_select, report_select_next;
  logic [CountW-1:0]  packets_left, packets_left_next;
  logic               deliver_current, deliver_current_next;
  logic [LenW-1:0]    max_packet_size;

  // values derived from descriptor word 0, settled long before they are used
  logic [7:0]         pkt_offset;
  logic [PosW-1:0]    pkt_stop;
  logic [PosW-1:0]    unit_bytes;

  logic               s_xfer;
  logic [DataW-1:0]   data_byte;
  logic [BlenW-1:0]   buffer_length;
  logic [BlenW-1:0]   blen;
  logic [PosW-1:0]    rel;
  logic [PosW:0]      rel_inc;
  logic [PosW:0]      pos_inc;
  logic [PosW-1:0]    remaining;
  logic [LenW-1:0]    pkt_len;
  logic               len_zero;
  logic [2:0]         sec;
  logic               sec_ok;
  logic               accept_ok;
  phase_t             cur_phase;
  logic               do_after;
  logic [CountW-1:0]  after_left;
  logic [CountW-1:0]  count_load;
  logic               res_valid, res_start, res_end;

  assign s_xfer        = s_tvalid && s_tready;
  assign s_tready      = !m_tvalid || m_tready;
  assign cfg_ready     = 1'b1;
  assign data_byte     = s_tdata[7:0];
  assign buffer_length = s_tdata[22:8];

  assign blen      = (17'(buffer_length) > BufLimit) ? BlenW'(BufLimit) : buffer_length;
  assign rel       = byte_position - unit_start;
  assign rel_inc   = {1'b0, rel} + 16'd1;
  assign pos_inc   = {1'b0, byte_position} + 16'd1;
  assign remaining = (blen > unit_start) ? (blen - unit_start) : '0;

  assign pkt_len  = descriptor_word_zero[LenW-1:0];
  assign len_zero = (pkt_len == '0);
  assign sec      = descriptor_word_zero[22:20];
  assign sec_ok   = (sec == SecNone) ||
                    ((sec == SecTkip || sec == SecAes) && !descriptor_word_zero[SwDecryptBit]);
  assign accept_ok = !len_zero && (pkt_len <= max_packet_size) &&
                     !descriptor_word_zero[CrcErrBit] && !descriptor_word_zero[IcvErrBit] &&
                     (report_select == 2'd0) && sec_ok;

  always_comb begin
    cur_phase = phase;
    if (phase != PH_STOP && byte_position >= blen) begin
      cur_phase = PH_STOP;
    end

    phase_next                = cur_phase;
    unit_start_next           = unit_start;
    descriptor_word_zero_next = descriptor_word_zero;
    report_select_next        = report_select;
    packets_left_next         = packets_left;
    deliver_current_next      = deliver_current;
    do_after                  = 1'b0;
    after_left                = packets_left;
    count_load                = (packets_left == '0) ? CountW'(1) : packets_left;
    res_valid                 = 1'b0;
    res_start                 = 1'b0;
    res_end                   = 1'b0;

    unique case (cur_phase)
      PH_DESC: begin
        if (rel == '0 && remaining < PosW'(DescBytes)) begin
          phase_next = PH_STOP;
        end else begin
          if (rel < PosW'(4)) begin
            descriptor_word_zero_next[{rel[1:0], 3'b000} +: 8] = data_byte;
          end else if (rel == RelCount && packets_left == '0) begin
            packets_left_next = data_byte;
          end else if (rel == RelReport) begin
            report_select_next = data_byte[7:6];
          end
          if (rel == PosW'(DescBytes) - PosW'(1)) begin
            // packet up to its last byte must fit in what is left of the transfer
            if (pkt_stop > remaining) begin
              phase_next = PH_STOP;
            end else begin
              packets_left_next    = count_load - CountW'(1);
              deliver_current_next = accept_ok;
              if (pkt_offset > DescBytes) begin
                phase_next = PH_GAP;
              end else if (len_zero) begin
                do_after   = 1'b1;
                after_left = count_load - CountW'(1);
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
        end
      end
      PH_GAP: begin
        if (rel_inc >= 16'(pkt_offset)) begin
          if (len_zero) begin
            do_after = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_valid = deliver_current;
        res_start = (rel == PosW'(pkt_offset));
        res_end   = (rel_inc == 16'(pkt_stop));
        if (rel_inc >= 16'(pkt_stop)) begin
          do_after = 1'b1;
        end
      end
      PH_PAD: begin
        if (pos_inc >= 16'(unit_start)) begin
          phase_next = PH_DESC;
        end
      end
      PH_STOP: begin
        phase_next = PH_STOP;
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase

    // end of a unit's packet: stop, or move on to the next aligned unit
    if (do_after) begin
      if (after_left == '0 || unit_bytes > remaining) begin
        phase_next = PH_STOP;
      end else begin
        unit_start_next = unit_start + unit_bytes;
        phase_next      = (rel_inc == 16'(unit_bytes)) ? PH_DESC : PH_PAD;
      end
    end

    byte_position_next = (byte_position != '1) ? pos_inc[PosW-1:0] : byte_position;

    if (s_tlast) begin
      phase_next                = PH_DESC;
      byte_position_next        = '0;
      unit_start_next           = '0;
      descriptor_word_zero_next = '0;
      report_select_next        = '0;
      packets_left_next         = '0;
      deliver_current_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                <= PH_DESC;
      byte_position        <= '0;
      unit_start           <= '0;
      descriptor_word_zero <= '0;
      report_select        <= '0;
      packets_left         <= '0;
      deliver_current      <= 1'b0;
      max_packet_size      <= MaxPacketReset;
      m_tvalid             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        max_packet_size <= cfg_data;
      end
      if (s_xfer) begin
        phase                <= phase_next;
        byte_position        <= byte_position_next;
        unit_start           <= unit_start_next;
        descriptor_word_zero <= descriptor_word_zero_next;
        report_select        <= report_select_next;
        packets_left         <= packets_left_next;
        deliver_current      <= deliver_current_next;
        m_tvalid             <= res_valid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // offset, packet end and aligned unit size follow descriptor word 0
  always_ff @(posedge clk) begin
    pkt_offset <= DescBytes + {1'b0, descriptor_word_zero[19:16], 3'b000} +
                  8'(descriptor_word_zero[25:24]);
    pkt_stop   <= PosW'(pkt_offset) + PosW'(pkt_len);
    unit_bytes <= (pkt_stop + PosW'(UnitAlign) - PosW'(1)) & ~(PosW'(UnitAlign) - PosW'(1));
  end

  // output register
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      m_tdata <= {(MTdataW - DataW - LenW)'(0), pkt_len, data_byte};
      m_tuser <= res_start;
      m_tlast <= res_end;
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while a result is stalled");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && s_tlast) |=> (phase == PH_DESC && byte_position == '0 && unit_start == '0))
    else $error("parse state not cleared after the last byte");

  a_start_keeps_deliver: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && res_valid && res_start && !res_end) |=> (deliver_current && phase == PH_PAYLOAD))
    else $error("packet dropped after its first byte");

  a_result_only_payload: assert property (@(posedge clk) disable iff (rst)
    (s_xfer && res_valid) |-> (cur_phase == PH_PAYLOAD && !len_zero))
    else $error("result outside a packet payload");

endmodule
